FILE: hw/rtl/pbf_pkg.sv
// Package for the pipe byte FIFO: command and status codes, end count width.
// No dependencies; imported by the top level.
package pbf_pkg;

    // Width of the reader and writer end counters.
    localparam int END_W = 8;

    // Command codes carried on the input channel.
    typedef enum logic [2:0] {
        CMD_WRITE    = 3'd0,
        CMD_READ     = 3'd1,
        CMD_CLOSE_WR = 3'd2,
        CMD_CLOSE_RD = 3'd3,
        CMD_OPEN_WR  = 3'd4,
        CMD_OPEN_RD  = 3'd5
    } t_cmd;

    // Status codes returned with each result beat.
    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_WOULD_BLOCK = 2'd1,
        ST_EOF         = 2'd2,
        ST_BROKEN_PIPE = 2'd3
    } t_status;

endpackage

FILE: hw/rtl/pbf_store.sv
// Byte store of the pipe FIFO: one write port and one registered read port.
// No package dependencies; instantiated by pipe_byte_fifo_with_end_counts.
module pbf_store #(
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [7:0]               i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [7:0]               o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; the data register holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/pipe_byte_fifo_with_end_counts.sv
// Top level of the pipe byte FIFO: command decode, position, level and end counts.
// Depends on pbf_pkg and pbf_store.
//
//  Channel   Direction  Handshake            Payload
//  input     in         i_valid / o_ready    i_command, i_data_in, i_request_end
//  result    out        o_valid / i_ready    o_status, o_data_out, o_fill_out,
//                                            o_released, o_last
//
// One beat is accepted per cycle unless a held result blocks o_ready; its result is
// registered and appears in the next cycle, from the store's registered read port.
// Reset is synchronous: position and level go to zero, both end counts to one.
// The byte store is not cleared; only counted bytes are ever read.
// A stalled result holds in the output register, and a new beat is taken in the
// same cycle that the waiting result leaves.
module pipe_byte_fifo_with_end_counts
    import pbf_pkg::*;
#(
    parameter int DEPTH    = 16384,
    parameter int MAX_ENDS = 255
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [2:0]                 i_command,
    input  logic [7:0]                 i_data_in,
    input  logic                       i_request_end,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [1:0]                 o_status,
    output logic [7:0]                 o_data_out,
    output logic [$clog2(DEPTH+1)-1:0] o_fill_out,
    output logic                       o_released,
    output logic                       o_last
);

    localparam int AW = $clog2(DEPTH);
    localparam int FW = $clog2(DEPTH + 1);

    // Architectural state.
    logic [AW-1:0]    r_rd_pos, n_rd_pos;
    logic [FW-1:0]    r_fill, n_fill;
    logic [END_W-1:0] r_readers, n_readers;
    logic [END_W-1:0] r_writers, n_writers;

    // Result register.
    logic             r_out_valid;
    t_status          r_status, n_status;
    logic [FW-1:0]    r_fill_out;
    logic             r_released, n_released;
    logic             r_last;
    logic             r_rd_ok, n_rd_ok;

    logic             accept;
    logic             mem_we;
    logic [AW-1:0]    tail_pos;
    logic [AW:0]      tail_sum;
    logic [AW:0]      head_sum;
    logic [7:0]       mem_q;
    logic             were_alive;

    assign o_ready = !r_out_valid || i_ready;
    assign accept  = i_valid && o_ready;

    // Tail and next head positions, wrapped at the buffer depth.
    assign tail_sum = (AW+1)'(r_rd_pos) + (AW+1)'(r_fill);
    assign head_sum = (AW+1)'(r_rd_pos) + (AW+1)'(1);
    assign tail_pos = (tail_sum >= (AW+1)'(DEPTH)) ? AW'(tail_sum - (AW+1)'(DEPTH))
                                                   : AW'(tail_sum);
    assign were_alive = (r_readers != '0) || (r_writers != '0);

    // Command decode and next state.
    always_comb begin
        n_rd_pos   = r_rd_pos;
        n_fill     = r_fill;
        n_readers  = r_readers;
        n_writers  = r_writers;
        n_status   = ST_OK;
        n_released = 1'b0;
        n_rd_ok    = 1'b0;
        mem_we     = 1'b0;
        case (t_cmd'(i_command))
            CMD_WRITE: begin
                if (r_readers == '0) begin
                    n_status = ST_BROKEN_PIPE;
                end else if (r_fill >= FW'(DEPTH)) begin
                    n_status = ST_WOULD_BLOCK;
                end else begin
                    mem_we = accept;
                    n_fill = r_fill + FW'(1);
                end
            end
            CMD_READ: begin
                if (r_fill == '0) begin
                    n_status = (r_writers == '0) ? ST_EOF : ST_WOULD_BLOCK;
                end else begin
                    n_rd_ok  = 1'b1;
                    n_rd_pos = (head_sum >= (AW+1)'(DEPTH)) ? '0 : AW'(head_sum);
                    n_fill   = r_fill - FW'(1);
                end
            end
            CMD_CLOSE_WR: begin
                if (r_writers != '0) begin
                    n_writers = r_writers - END_W'(1);
                end
            end
            CMD_CLOSE_RD: begin
                if (r_readers != '0) begin
                    n_readers = r_readers - END_W'(1);
                end
            end
            CMD_OPEN_WR: begin
                if (r_writers < END_W'(MAX_ENDS)) begin
                    n_writers = r_writers + END_W'(1);
                end
            end
            CMD_OPEN_RD: begin
                if (r_readers < END_W'(MAX_ENDS)) begin
                    n_readers = r_readers + END_W'(1);
                end
            end
            default: begin
            end
        endcase
        // The last open end just went away: drop all buffered bytes.
        if (were_alive && n_readers == '0 && n_writers == '0) begin
            n_released = 1'b1;
            n_rd_pos   = '0;
            n_fill     = '0;
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_pos  <= '0;
            r_fill    <= '0;
            r_readers <= END_W'(1);
            r_writers <= END_W'(1);
        end else if (accept) begin
            r_rd_pos  <= n_rd_pos;
            r_fill    <= n_fill;
            r_readers <= n_readers;
            r_writers <= n_writers;
        end
    end

    // Result valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_ready) begin
            r_out_valid <= i_valid;
        end
    end

    // Result payload, loaded with each accepted beat.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status   <= n_status;
            r_fill_out <= n_fill;
            r_released <= n_released;
            r_last     <= i_request_end;
            r_rd_ok    <= n_rd_ok;
        end
    end

    pbf_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (tail_pos),
        .i_wdata (i_data_in),
        .i_re    (accept && n_rd_ok),
        .i_raddr (r_rd_pos),
        .o_rdata (mem_q)
    );

    assign o_valid    = r_out_valid;
    assign o_status   = r_status;
    assign o_data_out = r_rd_ok ? mem_q : 8'd0;
    assign o_fill_out = r_fill_out;
    assign o_released = r_released;
    assign o_last     = r_last;

    // The level never exceeds the buffer depth.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(DEPTH))
        else $error("fill level above depth");

    // The read position stays inside the buffer.
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_pos <= AW'(DEPTH - 1))
        else $error("read position outside buffer");

    // A successful read lowers the level by exactly one.
    a_read_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && t_cmd'(i_command) == CMD_READ && r_fill != '0)
        |=> (r_fill == $past(r_fill) - FW'(1)))
        else $error("read did not consume one byte");

    // A release always leaves an empty buffer.
    a_release_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_released) |-> (r_fill_out == '0))
        else $error("release with bytes still counted");

endmodule
